// ----- src/cslex_pkg.sv -----
// Shared constants for the C subset lexer: token classes, keyword tables and field widths.
// Used by the channel interfaces, the lexer top level and its checker.
// No dependencies.
package cslex_pkg;

    // Field widths of the two channels
    localparam int SYM_W  = 8;
    localparam int KIND_W = 6;

    // Keyword table limits
    localparam int KEYWORD_MAX       = 6;
    localparam int KEYWORD_COUNT_DEF = 6;
    localparam int KW_POS            = 8;

    // Token classes
    localparam logic [KIND_W-1:0] TK_COMMA  = 6'd0;
    localparam logic [KIND_W-1:0] TK_SEMI   = 6'd1;
    localparam logic [KIND_W-1:0] TK_LPAR   = 6'd2;
    localparam logic [KIND_W-1:0] TK_RPAR   = 6'd3;
    localparam logic [KIND_W-1:0] TK_LBRC   = 6'd4;
    localparam logic [KIND_W-1:0] TK_RBRC   = 6'd5;
    localparam logic [KIND_W-1:0] TK_MUL    = 6'd6;
    localparam logic [KIND_W-1:0] TK_MOD    = 6'd7;
    localparam logic [KIND_W-1:0] TK_DIV    = 6'd8;
    localparam logic [KIND_W-1:0] TK_EOT    = 6'd9;
    localparam logic [KIND_W-1:0] TK_OR     = 6'd10;
    localparam logic [KIND_W-1:0] TK_AND    = 6'd12;
    localparam logic [KIND_W-1:0] TK_PLUS   = 6'd14;
    localparam logic [KIND_W-1:0] TK_MINUS  = 6'd16;
    localparam logic [KIND_W-1:0] TK_ASSIGN = 6'd18;
    localparam logic [KIND_W-1:0] TK_GT     = 6'd20;
    localparam logic [KIND_W-1:0] TK_LT     = 6'd21;
    localparam logic [KIND_W-1:0] TK_SHR    = 6'd22;
    localparam logic [KIND_W-1:0] TK_SHL    = 6'd23;
    localparam logic [KIND_W-1:0] TK_GE     = 6'd24;
    localparam logic [KIND_W-1:0] TK_LE     = 6'd25;
    localparam logic [KIND_W-1:0] TK_KW0    = 6'd26;
    localparam logic [KIND_W-1:0] TK_NE     = 6'd32;
    localparam logic [KIND_W-1:0] TK_ERR    = 6'd33;
    localparam logic [KIND_W-1:0] TK_IDENT  = 6'd34;
    localparam logic [KIND_W-1:0] TK_CINT   = 6'd35;
    localparam logic [KIND_W-1:0] TK_POINT  = 6'd36;
    localparam logic [KIND_W-1:0] TK_CFLOAT = 6'd37;
    localparam logic [KIND_W-1:0] TK_CEXP   = 6'd38;

    // Keyword spellings, padded with zero bytes so that any length index is in range
    localparam logic [SYM_W-1:0] KW_TEXT [KEYWORD_MAX][KW_POS] = '{
        '{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"e", "l", "s", "e", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"v", "o", "i", "d", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"i", "n", "t", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"d", "o", "u", "b", "l", "e", 8'd0, 8'd0},
        '{"m", "a", "i", "n", 8'd0, 8'd0, 8'd0, 8'd0}
    };

    localparam logic [2:0] KW_LEN [KEYWORD_MAX] = '{3'd2, 3'd4, 3'd4, 3'd3, 3'd6, 3'd4};

    // Single class of | & + - = ; the doubled class is one higher
    function automatic logic [KIND_W-1:0] dbl_single(logic [SYM_W-1:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            "|":     k = TK_OR;
            "&":     k = TK_AND;
            "+":     k = TK_PLUS;
            "-":     k = TK_MINUS;
            default: k = TK_ASSIGN;
        endcase
        return k;
    endfunction

endpackage

// ----- src/cslex_in_if.sv -----
// Character request channel of the C subset lexer.
// Depends on cslex_pkg for the symbol width.
interface cslex_in_if;
    logic                        valid;
    logic                        ready;
    logic [cslex_pkg::SYM_W-1:0] symbol;
    logic                        is_end;

    modport source (output valid, output symbol, output is_end, input ready);
    modport sink   (input valid, input symbol, input is_end, output ready);
endinterface

// ----- src/cslex_out_if.sv -----
// Token request channel of the C subset lexer.
// Depends on cslex_pkg for the token class width.
interface cslex_out_if;
    logic                         valid;
    logic                         ready;
    logic [cslex_pkg::KIND_W-1:0] token_kind;
    logic                         last;

    modport source (output valid, output token_kind, output last, input ready);
    modport sink   (input valid, input token_kind, input last, output ready);
endinterface

// ----- src/c_subset_lexer.sv -----
// Streaming lexer for a small C subset: one source character per request, token classes out.
// A token is written into the token queue as its character is taken and is offered from the
// queue head in order. One character per cycle while ready is high; a character that causes
// two tokens queues both in a four-entry token queue that drops ready while it holds over two.
// Reset (synchronous, active low) returns the lexer to idle and empties the token queue.
// Depends on cslex_pkg, cslex_in_if and cslex_out_if.
module c_subset_lexer #(
    parameter int KEYWORD_COUNT = cslex_pkg::KEYWORD_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cslex_in_if.sink    i_req,
    cslex_out_if.source o_tok
);

    localparam int KW = cslex_pkg::KIND_W;
    localparam int SW = cslex_pkg::SYM_W;

    // Lexer state codes
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SLASH   = 4'd1;
    localparam logic [3:0] ST_COMMENT = 4'd2;
    localparam logic [3:0] ST_DBL     = 4'd3;
    localparam logic [3:0] ST_BANG    = 4'd4;
    localparam logic [3:0] ST_ANGLE   = 4'd5;
    localparam logic [3:0] ST_IDENT   = 4'd6;
    localparam logic [3:0] ST_INT     = 4'd7;
    localparam logic [3:0] ST_DOT     = 4'd8;
    localparam logic [3:0] ST_FRAC    = 4'd9;
    localparam logic [3:0] ST_EXP     = 4'd10;
    localparam logic [3:0] ST_EXPSIGN = 4'd11;
    localparam logic [3:0] ST_EXPDIG  = 4'd12;

    // Lexer state
    logic [3:0]               r_state, n_state;
    logic [SW-1:0]            r_pend, n_pend;
    logic [KEYWORD_COUNT-1:0] r_mask, n_mask;
    logic [2:0]               r_len, n_len;

    // Token queue
    logic [KW-1:0] r_q_kind [4];
    logic          r_q_last [4];
    logic [1:0]    r_wr, r_rd;
    logic [2:0]    r_cnt;

    logic [SW-1:0] c;
    logic          take, pop;

    // Keywords whose character at position len equals c
    function automatic logic [KEYWORD_COUNT-1:0] kw_match(logic [2:0] len, logic [SW-1:0] ch);
        logic [KEYWORD_COUNT-1:0] m;
        m = '0;
        for (int i = 0; i < KEYWORD_COUNT; i++) begin
            if (cslex_pkg::KW_TEXT[i][len] == ch) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic is_digit(logic [SW-1:0] ch);
        return (ch >= "0") && (ch <= "9");
    endfunction

    function automatic logic is_alpha(logic [SW-1:0] ch);
        return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    endfunction

    assign c    = i_req.symbol;
    assign take = i_req.valid && i_req.ready;
    assign pop  = o_tok.valid && o_tok.ready;

    // Class of the token that is pending in the current state
    logic          pd_vld;
    logic [KW-1:0] pd_kind;

    always_comb begin
        pd_vld  = 1'b1;
        pd_kind = cslex_pkg::TK_ERR;
        unique case (r_state)
            ST_SLASH:   pd_kind = cslex_pkg::TK_DIV;
            ST_DBL:     pd_kind = cslex_pkg::dbl_single(r_pend);
            ST_BANG:    pd_kind = cslex_pkg::TK_ERR;
            ST_ANGLE:   pd_kind = (r_pend == ">") ? cslex_pkg::TK_GT : cslex_pkg::TK_LT;
            ST_IDENT: begin
                // The lowest matching keyword of the right length wins
                pd_kind = cslex_pkg::TK_IDENT;
                for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
                    if (r_mask[i] && (cslex_pkg::KW_LEN[i] == r_len)) begin
                        pd_kind = cslex_pkg::TK_KW0 + KW'(i);
                    end
                end
            end
            ST_INT:     pd_kind = cslex_pkg::TK_CINT;
            ST_DOT:     pd_kind = cslex_pkg::TK_POINT;
            ST_FRAC:    pd_kind = cslex_pkg::TK_CFLOAT;
            ST_EXP:     pd_kind = cslex_pkg::TK_CEXP;
            ST_EXPSIGN: pd_kind = cslex_pkg::TK_ERR;
            ST_EXPDIG:  pd_kind = cslex_pkg::TK_CEXP;
            default:    pd_vld  = 1'b0;
        endcase
    end

    // Outcome of starting a new token with c from idle
    logic [3:0]    st_state;
    logic          st_emit, st_pend_ld, st_ident;
    logic [KW-1:0] st_kind;

    always_comb begin
        st_state   = ST_IDLE;
        st_emit    = 1'b0;
        st_kind    = cslex_pkg::TK_ERR;
        st_pend_ld = 1'b0;
        st_ident   = 1'b0;
        case (c) inside
            " ", 8'h09, 8'h0D, 8'h0A: ;
            "/":                st_state = ST_SLASH;
            ",":                begin st_emit = 1'b1; st_kind = cslex_pkg::TK_COMMA; end
            ";":                begin st_emit = 1'b1; st_kind = cslex_pkg::TK_SEMI; end
            "(":                begin st_emit = 1'b1; st_kind = cslex_pkg::TK_LPAR; end
            ")":                begin st_emit = 1'b1; st_kind = cslex_pkg::TK_RPAR; end
            "{":                begin st_emit = 1'b1; st_kind = cslex_pkg::TK_LBRC; end
            "}":                begin st_emit = 1'b1; st_kind = cslex_pkg::TK_RBRC; end
            "*":                begin st_emit = 1'b1; st_kind = cslex_pkg::TK_MUL; end
            "%":                begin st_emit = 1'b1; st_kind = cslex_pkg::TK_MOD; end
            "|", "&", "+", "-", "=": begin
                st_state   = ST_DBL;
                st_pend_ld = 1'b1;
            end
            "!":                st_state = ST_BANG;
            ">", "<": begin
                st_state   = ST_ANGLE;
                st_pend_ld = 1'b1;
            end
            ".":                st_state = ST_DOT;
            ["a":"z"], ["A":"Z"]: begin
                st_state = ST_IDENT;
                st_ident = 1'b1;
            end
            ["0":"9"]:          st_state = ST_INT;
            default:            begin st_emit = 1'b1; st_kind = cslex_pkg::TK_ERR; end
        endcase
    end

    // Outcome of offering c to the pending token
    logic          ab_ok, ab_emit, ab_ident, is_e;
    logic [3:0]    ab_state;
    logic [KW-1:0] ab_kind;

    assign is_e = (c == "e") || (c == "E");

    always_comb begin
        ab_ok    = 1'b0;
        ab_emit  = 1'b0;
        ab_ident = 1'b0;
        ab_state = r_state;
        ab_kind  = cslex_pkg::TK_ERR;
        unique case (r_state)
            ST_SLASH: begin
                if (c == "/") begin
                    ab_ok    = 1'b1;
                    ab_state = ST_COMMENT;
                end
            end
            ST_COMMENT: begin
                // Comment runs to the end of the line and swallows the line end
                ab_ok = 1'b1;
                if ((c == 8'h0D) || (c == 8'h0A)) begin
                    ab_state = ST_IDLE;
                end
            end
            ST_DBL: begin
                if (c == r_pend) begin
                    ab_ok    = 1'b1;
                    ab_emit  = 1'b1;
                    ab_kind  = cslex_pkg::dbl_single(r_pend) + KW'(1);
                    ab_state = ST_IDLE;
                end
            end
            ST_BANG: begin
                if (c == "=") begin
                    ab_ok    = 1'b1;
                    ab_emit  = 1'b1;
                    ab_kind  = cslex_pkg::TK_NE;
                    ab_state = ST_IDLE;
                end
            end
            ST_ANGLE: begin
                if (c == r_pend) begin
                    ab_ok    = 1'b1;
                    ab_emit  = 1'b1;
                    ab_kind  = (c == ">") ? cslex_pkg::TK_SHR : cslex_pkg::TK_SHL;
                    ab_state = ST_IDLE;
                end else if (c == "=") begin
                    ab_ok    = 1'b1;
                    ab_emit  = 1'b1;
                    ab_kind  = (r_pend == ">") ? cslex_pkg::TK_GE : cslex_pkg::TK_LE;
                    ab_state = ST_IDLE;
                end
            end
            ST_IDENT: begin
                if (is_alpha(c) || is_digit(c)) begin
                    ab_ok    = 1'b1;
                    ab_ident = 1'b1;
                end
            end
            ST_INT: begin
                if (is_digit(c)) begin
                    ab_ok = 1'b1;
                end else if (c == ".") begin
                    ab_ok    = 1'b1;
                    ab_state = ST_FRAC;
                end else if (is_e) begin
                    ab_ok    = 1'b1;
                    ab_state = ST_EXP;
                end
            end
            ST_DOT: begin
                if (is_digit(c)) begin
                    ab_ok    = 1'b1;
                    ab_state = ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (is_digit(c)) begin
                    ab_ok = 1'b1;
                end else if (is_e) begin
                    ab_ok    = 1'b1;
                    ab_state = ST_EXP;
                end
            end
            ST_EXP: begin
                if ((c == "+") || (c == "-")) begin
                    ab_ok    = 1'b1;
                    ab_state = ST_EXPSIGN;
                end else if (is_digit(c)) begin
                    ab_ok    = 1'b1;
                    ab_state = ST_EXPDIG;
                end
            end
            ST_EXPSIGN, ST_EXPDIG: begin
                if (is_digit(c)) begin
                    ab_ok    = 1'b1;
                    ab_state = ST_EXPDIG;
                end
            end
            default: ab_ok = 1'b0;
        endcase
    end

    // Combine: first token from the pending side, second from the start side
    logic          active;
    logic          a_vld, b_vld;
    logic [KW-1:0] a_kind, b_kind;

    assign active = (r_state != ST_IDLE) && (r_state <= ST_EXPDIG);

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_mask  = r_mask;
        n_len   = r_len;
        a_vld   = 1'b0;
        a_kind  = pd_kind;
        b_vld   = 1'b0;
        b_kind  = st_kind;
        if (i_req.is_end) begin
            // End of text flushes the pending token, then marks the end
            a_vld   = pd_vld;
            b_vld   = 1'b1;
            b_kind  = cslex_pkg::TK_EOT;
            n_state = ST_IDLE;
        end else if (active && ab_ok) begin
            a_vld   = ab_emit;
            a_kind  = ab_kind;
            n_state = ab_state;
            if (ab_ident) begin
                n_mask = r_mask & kw_match(r_len, c);
                n_len  = (r_len == 3'd7) ? r_len : r_len + 3'd1;
            end
        end else begin
            // The character closes any pending token and is lexed afresh
            a_vld   = active && pd_vld;
            b_vld   = st_emit;
            n_state = st_state;
            if (st_pend_ld) begin
                n_pend = c;
            end
            if (st_ident) begin
                n_mask = kw_match(3'd0, c);
                n_len  = 3'd1;
            end
        end
    end

    // Tokens to queue this cycle
    logic          s0_vld, s1_vld;
    logic [KW-1:0] s0_kind;
    logic [1:0]    push;

    assign s0_vld  = a_vld || b_vld;
    assign s1_vld  = a_vld && b_vld;
    assign s0_kind = a_vld ? a_kind : b_kind;
    assign push    = take ? ({1'b0, a_vld} + {1'b0, b_vld}) : 2'd0;

    // Lexer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= '0;
            r_mask  <= '0;
            r_len   <= '0;
        end else if (take) begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_mask  <= n_mask;
            r_len   <= n_len;
        end
    end

    // Token queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + push;
            r_rd  <= r_rd + {1'b0, pop};
            r_cnt <= r_cnt + {1'b0, push} - {2'b0, pop};
        end
    end

    // Token queue storage
    always_ff @(posedge i_clk) begin
        if (take && s0_vld) begin
            r_q_kind[r_wr] <= s0_kind;
            r_q_last[r_wr] <= !s1_vld;
        end
        if (take && s1_vld) begin
            r_q_kind[r_wr + 2'd1] <= b_kind;
            r_q_last[r_wr + 2'd1] <= 1'b1;
        end
    end

    // Channel outputs
    assign i_req.ready      = (r_cnt <= 3'd2);
    assign o_tok.valid      = (r_cnt != 3'd0);
    assign o_tok.token_kind = r_q_kind[r_rd];
    assign o_tok.last       = r_q_last[r_rd];

endmodule

// ----- src/cslex_chk.sv -----
// Port checker for the C subset lexer, attached to the top level by the bind below.
// Depends on cslex_pkg for the token class width.
module cslex_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_req_is_end,
    input logic                         o_tok_valid,
    input logic                         o_tok_ready,
    input logic [cslex_pkg::KIND_W-1:0] o_tok_token_kind,
    input logic                         o_tok_last
);

    // Nothing is offered in the first cycle after reset
    a_idle_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_tok_valid)
        else $error("token offered straight after reset");

    // A stalled token holds its value
    a_tok_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_valid && !o_tok_ready) |=>
            (o_tok_valid && $stable(o_tok_token_kind) && $stable(o_tok_last)))
        else $error("stalled token changed");

    // End of text always yields a token on the next cycle
    a_end_gives_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && i_req_is_end) |=> o_tok_valid)
        else $error("end of text gave no token");

    // Back-pressure on the input only when tokens are waiting
    a_stall_has_tokens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> o_tok_valid)
        else $error("input stalled with no tokens queued");

endmodule

bind c_subset_lexer cslex_chk u_cslex_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_req_is_end     (i_req.is_end),
    .o_tok_valid      (o_tok.valid),
    .o_tok_ready      (o_tok.ready),
    .o_tok_token_kind (o_tok.token_kind),
    .o_tok_last       (o_tok.last)
);

// ----- dv/tb_c_subset_lexer.sv -----
// Self-checking testbench for the C subset lexer: characters in, token classes out.
// A token ledger predicts every token of each accepted character and checks them in order.
// Depends on cslex_pkg, cslex_in_if, cslex_out_if and c_subset_lexer.
`timescale 1ns / 100ps

module tb_c_subset_lexer;
    import cslex_pkg::*;

    localparam real CLK_PERIOD   = 4.0;
    localparam int  KW_COUNT     = KEYWORD_COUNT_DEF;
    localparam int  TOTAL_CHARS  = 1550;
    localparam int  HOLD_AT      = 400;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  CYCLE_LIMIT  = 200000;

    localparam logic [SYM_W-1:0] CH_TAB = 8'd9;
    localparam logic [SYM_W-1:0] CH_LF  = 8'd10;
    localparam logic [SYM_W-1:0] CH_CR  = 8'd13;

    // Scanner modes of the shadow lexer
    typedef enum logic [4:0] {
        LX_IDLE, LX_SLASH, LX_COMMENT, LX_DOUBLE, LX_BANG, LX_ANGLE, LX_IDENT,
        LX_INT, LX_DOT, LX_FRAC, LX_EXP, LX_EXP_SIGN, LX_EXP_DIGIT
    } lex_mode_e;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             eot;
    } char_item_t;

    // Shadow lexer plus the queue of tokens still owed by the block.
    class token_ledger;
        lex_mode_e         mode;
        logic [SYM_W-1:0]  pend_char;
        logic [5:0]        kw_live;
        logic [2:0]        id_len;
        int                kw_count;
        string             kw_spell [6];
        logic [KIND_W-1:0] step_kinds [$];
        logic [KIND_W-1:0] due_kind [$];
        bit                due_last [$];
        int                mismatches;

        function new(int count);
            kw_spell   = '{"if", "else", "void", "int", "double", "main"};
            kw_count   = count;
            mode       = LX_IDLE;
            pend_char  = '0;
            kw_live    = '0;
            id_len     = '0;
            mismatches = 0;
        endfunction

        task report(string what);
            $display("%0t MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        function bit is_letter(logic [SYM_W-1:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_digit(logic [SYM_W-1:0] c);
            return c >= "0" && c <= "9";
        endfunction

        // Class of | & + - = written once or twice.
        function logic [KIND_W-1:0] op_class(logic [SYM_W-1:0] c, bit twice);
            logic [KIND_W-1:0] k;
            case (c)
                "|":     k = TK_OR;
                "&":     k = TK_AND;
                "+":     k = TK_PLUS;
                "-":     k = TK_MINUS;
                default: k = TK_ASSIGN;
            endcase
            return k + KIND_W'(twice);
        endfunction

        function void emit(logic [KIND_W-1:0] kind);
            if (step_kinds.size() < 2) step_kinds.push_back(kind);
        endfunction

        // Narrow the set of keywords that still match the identifier so far.
        function void track_keyword(logic [SYM_W-1:0] c);
            logic [5:0] hit;
            hit = '0;
            for (int i = 0; i < kw_count && i < 6; i++) begin
                if (id_len < kw_spell[i].len() && kw_spell[i][id_len] == c) hit[i] = 1'b1;
            end
            kw_live &= hit;
            if (id_len < 3'd7) id_len++;
        endfunction

        // Emit the token that the current mode holds, if any.
        function void flush_pending();
            int k;
            k = -1;
            case (mode)
                LX_SLASH:                  k = TK_DIV;
                LX_DOUBLE:                 k = op_class(pend_char, 1'b0);
                LX_BANG, LX_EXP_SIGN:      k = TK_ERR;
                LX_ANGLE:                  k = (pend_char == ">") ? TK_GT : TK_LT;
                LX_INT:                    k = TK_CINT;
                LX_DOT:                    k = TK_POINT;
                LX_FRAC:                   k = TK_CFLOAT;
                LX_EXP, LX_EXP_DIGIT:      k = TK_CEXP;
                LX_IDENT: begin
                    k = TK_IDENT;
                    for (int i = 5; i >= 0; i--) begin
                        if (kw_live[i] && kw_spell[i].len() == id_len) k = TK_KW0 + i;
                    end
                end
                default:                   k = -1;
            endcase
            if (k >= 0) emit(KIND_W'(k));
        endfunction

        // Begin a new token from the idle mode.
        function void start_token(logic [SYM_W-1:0] c);
            mode = LX_IDLE;
            case (c)
                " ", CH_TAB, CH_CR, CH_LF: ;
                "/": mode = LX_SLASH;
                ",": emit(TK_COMMA);
                ";": emit(TK_SEMI);
                "(": emit(TK_LPAR);
                ")": emit(TK_RPAR);
                "{": emit(TK_LBRC);
                "}": emit(TK_RBRC);
                "*": emit(TK_MUL);
                "%": emit(TK_MOD);
                "|", "&", "+", "-", "=": begin
                    pend_char = c;
                    mode      = LX_DOUBLE;
                end
                "!": mode = LX_BANG;
                ">", "<": begin
                    pend_char = c;
                    mode      = LX_ANGLE;
                end
                ".": mode = LX_DOT;
                default: begin
                    if (is_letter(c)) begin
                        mode    = LX_IDENT;
                        kw_live = 6'h3F;
                        id_len  = '0;
                        track_keyword(c);
                    end else if (is_digit(c)) begin
                        mode = LX_INT;
                    end else begin
                        emit(TK_ERR);
                    end
                end
            endcase
        endfunction

        // Work out the tokens caused by one accepted character and queue them.
        function void note_char(logic [SYM_W-1:0] c, logic eot);
            bit taken;
            bit is_e;
            step_kinds.delete();
            if (eot) begin
                flush_pending();
                emit(TK_EOT);
                mode = LX_IDLE;
            end else if (mode == LX_IDLE) begin
                start_token(c);
            end else begin
                taken = 1'b1;
                is_e  = (c == "e" || c == "E");
                case (mode)
                    LX_SLASH: begin
                        if (c == "/") mode = LX_COMMENT;
                        else taken = 1'b0;
                    end
                    LX_COMMENT: begin
                        if (c == CH_CR || c == CH_LF) mode = LX_IDLE;
                    end
                    LX_DOUBLE: begin
                        if (c == pend_char) begin
                            emit(op_class(c, 1'b1));
                            mode = LX_IDLE;
                        end else taken = 1'b0;
                    end
                    LX_BANG: begin
                        if (c == "=") begin
                            emit(TK_NE);
                            mode = LX_IDLE;
                        end else taken = 1'b0;
                    end
                    LX_ANGLE: begin
                        if (c == pend_char) begin
                            emit((c == ">") ? TK_SHR : TK_SHL);
                            mode = LX_IDLE;
                        end else if (c == "=") begin
                            emit((pend_char == ">") ? TK_GE : TK_LE);
                            mode = LX_IDLE;
                        end else taken = 1'b0;
                    end
                    LX_IDENT: begin
                        if (is_letter(c) || is_digit(c)) track_keyword(c);
                        else taken = 1'b0;
                    end
                    LX_INT: begin
                        if (c == ".") mode = LX_FRAC;
                        else if (is_e) mode = LX_EXP;
                        else if (!is_digit(c)) taken = 1'b0;
                    end
                    LX_DOT: begin
                        if (is_digit(c)) mode = LX_FRAC;
                        else taken = 1'b0;
                    end
                    LX_FRAC: begin
                        if (is_e) mode = LX_EXP;
                        else if (!is_digit(c)) taken = 1'b0;
                    end
                    LX_EXP: begin
                        if (c == "+" || c == "-") mode = LX_EXP_SIGN;
                        else if (is_digit(c)) mode = LX_EXP_DIGIT;
                        else taken = 1'b0;
                    end
                    LX_EXP_SIGN, LX_EXP_DIGIT: begin
                        if (is_digit(c)) mode = LX_EXP_DIGIT;
                        else taken = 1'b0;
                    end
                    default: taken = 1'b0;
                endcase
                // A character that does not extend the token ends it and starts afresh.
                if (!taken) begin
                    flush_pending();
                    start_token(c);
                end
            end
            foreach (step_kinds[i]) begin
                due_kind.push_back(step_kinds[i]);
                due_last.push_back(i == step_kinds.size() - 1);
            end
        endfunction

        // Compare one accepted token with the oldest one owed.
        task check_token(logic [KIND_W-1:0] kind, logic last);
            logic [KIND_W-1:0] want_kind;
            bit                want_last;
            if (due_kind.size() == 0) begin
                report($sformatf("token %0d arrived with none outstanding", kind));
            end else begin
                want_kind = due_kind.pop_front();
                want_last = due_last.pop_front();
                if (kind !== want_kind)
                    report($sformatf("token_kind %0d, wanted %0d", kind, want_kind));
                if (last !== want_last)
                    report($sformatf("last %0b on kind %0d, wanted %0b", last, want_kind,
                                     want_last));
            end
        endtask

        function bit all_arrived();
            return due_kind.size() == 0;
        endfunction

        task report_leftovers();
            if (due_kind.size() != 0)
                report($sformatf("%0d tokens never arrived", due_kind.size()));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    cslex_in_if  req_if ();
    cslex_out_if tok_if ();

    c_subset_lexer #(
        .KEYWORD_COUNT (KW_COUNT)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_tok   (tok_if)
    );

    token_ledger tokens = new(KW_COUNT);
    char_item_t  src_chars [$];
    int          chars_taken = 0;
    int          cycles = 0;

    string kw_words [6] = '{"if", "else", "void", "int", "double", "main"};
    string op_spell [29] = '{",", ";", "(", ")", "{", "}", "*", "%", "/", "|", "||", "&",
                             "&&", "+", "++", "-", "--", "=", "==", "!=", "!", ">", "<",
                             ">>", "<<", ">=", "<=", ".", "!!"};

    // Clock generation.
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_c_subset_lexer: errors");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge; characters are noted before tokens.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                tokens.note_char(req_if.symbol, req_if.is_end);
                chars_taken++;
            end
            if (tok_if.valid && tok_if.ready) tokens.check_token(tok_if.token_kind, tok_if.last);
        end
    end

    function void put_char(logic [SYM_W-1:0] c);
        src_chars.push_back('{sym: c, eot: 1'b0});
    endfunction

    function void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endfunction

    // End of text carries a random byte that the block must ignore.
    function void put_end();
        src_chars.push_back('{sym: SYM_W'($urandom_range(0, 255)), eot: 1'b1});
    endfunction

    function logic [SYM_W-1:0] rand_letter();
        int v;
        v = $urandom_range(0, 51);
        return (v < 26) ? SYM_W'("a" + v) : SYM_W'("A" + v - 26);
    endfunction

    function logic [SYM_W-1:0] rand_digit();
        return SYM_W'("0" + $urandom_range(0, 9));
    endfunction

    function logic [SYM_W-1:0] rand_alnum();
        return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
    endfunction

    function void put_digits(int lo, int hi);
        int n;
        n = $urandom_range(lo, hi);
        for (int i = 0; i < n; i++) put_char(rand_digit());
    endfunction

    // One random lexeme, mostly well formed, followed by an optional blank.
    function void add_fragment();
        int               pick;
        int               v;
        string            w;
        logic [SYM_W-1:0] b;
        pick = $urandom_range(0, 29);
        if (pick <= 3) begin
            w = kw_words[$urandom_range(0, 5)];
            v = $urandom_range(0, 3);
            if (v == 0) begin
                put_text(w.substr(0, w.len() - 2));
            end else begin
                put_text(w);
                if (v == 1) put_char(rand_alnum());
            end
        end else if (pick <= 6) begin
            put_char(rand_letter());
            v = $urandom_range(0, 8);
            for (int i = 0; i < v; i++) put_char(rand_alnum());
        end else if (pick <= 8) begin
            put_digits(1, 5);
        end else if (pick <= 10) begin
            v = $urandom_range(0, 2);
            if (v != 2) put_digits(1, 3);
            put_char(".");
            if (v != 1) put_digits(1, 3);
        end else if (pick <= 13) begin
            put_digits(1, 3);
            if ($urandom_range(0, 1)) begin
                put_char(".");
                put_digits(0, 2);
            end
            put_char($urandom_range(0, 1) ? "e" : "E");
            v = $urandom_range(0, 3);
            if (v == 0 || v == 2) put_char($urandom_range(0, 1) ? "+" : "-");
            if (v <= 1) put_digits(1, 3);
        end else if (pick <= 20) begin
            put_text(op_spell[$urandom_range(0, $size(op_spell) - 1)]);
        end else if (pick <= 22) begin
            put_text("//");
            v = $urandom_range(0, 10);
            for (int i = 0; i < v; i++) begin
                b = SYM_W'($urandom_range(0, 255));
                if (b == CH_CR || b == CH_LF) b = "x";
                put_char(b);
            end
            // Now and then the comment is left open for later blanks to close.
            if ($urandom_range(0, 7) != 0) put_char($urandom_range(0, 1) ? CH_CR : CH_LF);
        end else if (pick <= 25) begin
            put_char(SYM_W'($urandom_range(0, 255)));
        end else if (pick == 26) begin
            put_end();
        end else begin
            put_char(rand_letter());
        end
        case ($urandom_range(0, 7))
            4:       put_char(" ");
            5:       put_char(CH_TAB);
            6:       put_char(CH_CR);
            7:       put_char(CH_LF);
            default: ;
        endcase
    endfunction

    // Offer the characters in bursts of random length with random gaps between them.
    task automatic send_chars();
        int idx;
        int burst;
        int gap;
        idx = 0;
        while (idx < src_chars.size()) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
            for (int b = 0; b < burst && idx < src_chars.size(); b++) begin
                @(negedge i_clk);
                req_if.valid  <= 1'b1;
                req_if.symbol <= src_chars[idx].sym;
                req_if.is_end <= src_chars[idx].eot;
                do @(posedge i_clk); while (!req_if.ready);
                idx++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                req_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        req_if.valid <= 1'b0;
    endtask

    // Token receiver: a changing stall pattern, with one long hold-off part way through.
    initial begin
        int  rx_mode;
        int  mode_left;
        bit  held;
        tok_if.ready = 1'b0;
        rx_mode      = 0;
        mode_left    = 0;
        held         = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held && chars_taken >= HOLD_AT) begin
                held = 1'b1;
                tok_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (rx_mode)
                0:       tok_if.ready <= 1'b1;
                1:       tok_if.ready <= $urandom_range(0, 1);
                2:       tok_if.ready <= ($urandom_range(0, 7) != 0);
                default: tok_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Reset, stimulus and the final verdict.
    initial begin
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.symbol = '0;
        req_if.is_end = 1'b0;

        // Directed text: end with nothing pending, doubled and compare operators, a bang
        // without equals, an exponent sign without digit, extreme bytes, a comment, and a
        // keyword flushed by end of text.
        put_end();
        put_text("if ==!<=>> 9.e+x");
        put_char(8'h00);
        put_char(8'hFF);
        put_text("//a");
        put_char(CH_LF);
        put_text("int");
        put_end();

        while (src_chars.size() < TOTAL_CHARS) add_fragment();
        put_end();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_chars();
        while (!tokens.all_arrived()) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tokens.report_leftovers();

        if (tokens.mismatches == 0) begin
            $display("tb_c_subset_lexer: clean");
        end else begin
            $display("tb_c_subset_lexer: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/cslex_pkg.sv
src/cslex_in_if.sv
src/cslex_out_if.sv
src/c_subset_lexer.sv
src/cslex_chk.sv
dv/tb_c_subset_lexer.sv
